/* rtl/int64_divide_remainder_defines.svh */
// Assertion macros used by the divider top level.
`ifndef INT64_DIVIDE_REMAINDER_DEFINES_SVH
`define INT64_DIVIDE_REMAINDER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define IDR_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define IDR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/idr_pkg.sv */
// Shared types and constants for the pipelined restoring divider.
package idr_pkg;

   localparam int PORT_WIDTH         = 64;
   localparam int DATA_WIDTH_DEFAULT = 64;

   // Control that travels alongside each transaction through the cell chain.
   typedef struct packed {
      logic valid;
      logic zero_div;   // divisor was zero: quotient forced to 0
      logic q_neg;      // operand signs differ
      logic r_neg;      // dividend was negative and divisor nonzero
   } flags_type;

endpackage

/* rtl/idr_prep.sv */
// Entry stage: operand magnitudes and sign bookkeeping.
module idr_prep #(
   parameter int DATA_WIDTH = idr_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic                            signed_mode,
   input  logic [idr_pkg::PORT_WIDTH-1:0]  dividend,
   input  logic [idr_pkg::PORT_WIDTH-1:0]  divisor,
   output idr_pkg::flags_type              flags_out,
   output logic [DATA_WIDTH-1:0]           rem_out,
   output logic [DATA_WIDTH-1:0]           nq_out,
   output logic [DATA_WIDTH-1:0]           den_out
);
   import idr_pkg::*;

   logic [DATA_WIDTH-1:0] a;
   logic [DATA_WIDTH-1:0] b;
   logic                  b_zero;
   logic                  a_neg;
   logic                  b_neg;
   flags_type             flags_in;
   flags_type             flags_ff;
   logic [DATA_WIDTH-1:0] nq_in;
   logic [DATA_WIDTH-1:0] den_in;
   logic [DATA_WIDTH-1:0] nq_ff;
   logic [DATA_WIDTH-1:0] den_ff;

   always_comb begin
      a      = dividend[DATA_WIDTH-1:0];
      b      = divisor[DATA_WIDTH-1:0];
      b_zero = (b == '0);
      // zero divisor keeps raw bits so the chain leaves the dividend as remainder
      a_neg  = signed_mode & a[DATA_WIDTH-1] & ~b_zero;
      b_neg  = signed_mode & b[DATA_WIDTH-1] & ~b_zero;
      nq_in  = a_neg ? DATA_WIDTH'(~a + 1'b1) : a;
      den_in = b_neg ? DATA_WIDTH'(~b + 1'b1) : b;
      flags_in.valid    = in_valid;
      flags_in.zero_div = b_zero;
      flags_in.q_neg    = a_neg ^ b_neg;
      flags_in.r_neg    = a_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (en) begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nq_ff  <= nq_in;
         den_ff <= den_in;
      end
   end

   assign flags_out = flags_ff;
   assign rem_out   = '0;
   assign nq_out    = nq_ff;
   assign den_out   = den_ff;

endmodule

/* rtl/idr_cell.sv */
// One restoring shift-and-subtract step, registered.
module idr_cell #(
   parameter int DATA_WIDTH = idr_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  idr_pkg::flags_type     flags_in,
   input  logic [DATA_WIDTH-1:0]  rem_in,
   input  logic [DATA_WIDTH-1:0]  nq_in,
   input  logic [DATA_WIDTH-1:0]  den_in,
   output idr_pkg::flags_type     flags_out,
   output logic [DATA_WIDTH-1:0]  rem_out,
   output logic [DATA_WIDTH-1:0]  nq_out,
   output logic [DATA_WIDTH-1:0]  den_out
);
   import idr_pkg::*;

   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   diff;
   logic                  take;
   logic [DATA_WIDTH-1:0] rem_nx;
   logic [DATA_WIDTH-1:0] nq_nx;
   flags_type             flags_ff;
   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] nq_ff;
   logic [DATA_WIDTH-1:0] den_ff;

   // partial remainder stays below the divisor, so the difference fits in
   // W+1 bits and its top bit is the borrow
   always_comb begin
      shifted = {rem_in, nq_in[DATA_WIDTH-1]};
      diff    = shifted - {1'b0, den_in};
      take    = ~diff[DATA_WIDTH];
      rem_nx  = take ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      nq_nx   = {nq_in[DATA_WIDTH-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (en) begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_nx;
         nq_ff  <= nq_nx;
         den_ff <= den_in;
      end
   end

   assign flags_out = flags_ff;
   assign rem_out   = rem_ff;
   assign nq_out    = nq_ff;
   assign den_out   = den_ff;

endmodule

/* rtl/idr_fix.sv */
// Exit logic: sign correction and zero-divisor override.
module idr_fix #(
   parameter int DATA_WIDTH = idr_pkg::DATA_WIDTH_DEFAULT
) (
   input  idr_pkg::flags_type                flags_in,
   input  logic [DATA_WIDTH-1:0]             rem_in,
   input  logic [DATA_WIDTH-1:0]             quo_in,
   output logic [idr_pkg::PORT_WIDTH-1:0]    quotient,
   output logic [idr_pkg::PORT_WIDTH-1:0]    remainder
);
   import idr_pkg::*;

   logic [DATA_WIDTH-1:0] q;
   logic [DATA_WIDTH-1:0] r;

   always_comb begin
      if (flags_in.zero_div) begin
         q = '0;
      end else if (flags_in.q_neg) begin
         q = DATA_WIDTH'(~quo_in + 1'b1);
      end else begin
         q = quo_in;
      end
      r = flags_in.r_neg ? DATA_WIDTH'(~rem_in + 1'b1) : rem_in;
      quotient  = PORT_WIDTH'(q);
      remainder = PORT_WIDTH'(r);
   end

endmodule

/* rtl/int64_divide_remainder.sv */
// Top level: pipelined radix-2 restoring divider with quotient and remainder.
//
//  port group   direction  payload
//  req_         in         signed_mode, dividend, divisor
//  rsp_         out        quotient, remainder
//
//  One transaction per cycle sustained while the output is taken; stages:
//  entry stage, one cell per quotient bit, output register.
//  The chain shifts as a whole; it stops only when the last cell holds a
//  result and the output register is full and not being taken.
//  Synchronous reset clears the valid flags; data registers are not reset.
`include "int64_divide_remainder_defines.svh"

module int64_divide_remainder #(
   parameter int DATA_WIDTH = idr_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_signed_mode,
   input  logic [idr_pkg::PORT_WIDTH-1:0]  req_dividend,
   input  logic [idr_pkg::PORT_WIDTH-1:0]  req_divisor,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [idr_pkg::PORT_WIDTH-1:0]  rsp_quotient,
   output logic [idr_pkg::PORT_WIDTH-1:0]  rsp_remainder
);
   import idr_pkg::*;

   flags_type             flags [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] rem   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] nq    [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] den   [0:DATA_WIDTH];

   logic                  en;
   logic                  load;
   logic [PORT_WIDTH-1:0] quo_fix;
   logic [PORT_WIDTH-1:0] rem_fix;
   logic                  rsp_valid_in;
   logic                  rsp_valid_ff;
   logic [PORT_WIDTH-1:0] rsp_quotient_ff;
   logic [PORT_WIDTH-1:0] rsp_remainder_ff;

   assign en   = ~flags[DATA_WIDTH].valid | ~rsp_valid_ff | rsp_ready;
   assign load = en & flags[DATA_WIDTH].valid;
   assign req_ready = en;

   idr_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_valid),
      .signed_mode (req_signed_mode),
      .dividend    (req_dividend),
      .divisor     (req_divisor),
      .flags_out   (flags[0]),
      .rem_out     (rem[0]),
      .nq_out      (nq[0]),
      .den_out     (den[0])
   );

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      idr_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .flags_in  (flags[i]),
         .rem_in    (rem[i]),
         .nq_in     (nq[i]),
         .den_in    (den[i]),
         .flags_out (flags[i+1]),
         .rem_out   (rem[i+1]),
         .nq_out    (nq[i+1]),
         .den_out   (den[i+1])
      );
   end

   idr_fix #(.DATA_WIDTH(DATA_WIDTH)) u_fix (
      .flags_in  (flags[DATA_WIDTH]),
      .rem_in    (rem[DATA_WIDTH]),
      .quo_in    (nq[DATA_WIDTH]),
      .quotient  (quo_fix),
      .remainder (rem_fix)
   );

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_quotient_ff  <= quo_fix;
         rsp_remainder_ff <= rem_fix;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_quotient  = rsp_quotient_ff;
   assign rsp_remainder = rsp_remainder_ff;

   // chain must stop while a finished result is blocked behind a full output
   `IDR_ASSERT_SAME(a_stall_blocks_input,
                    flags[DATA_WIDTH].valid && rsp_valid_ff && !rsp_ready,
                    !req_ready, "input accepted while chain stalled")
   // an empty last cell never holds the chain
   `IDR_ASSERT_SAME(a_empty_tail_moves, !flags[DATA_WIDTH].valid, req_ready,
                    "chain stalled with empty tail")
   // a result handed to the output register is presented next cycle
   `IDR_ASSERT_NEXT(a_load_presents, load, rsp_valid, "loaded result not presented")
   // divide by zero always yields a zero quotient
   `IDR_ASSERT_NEXT(a_zero_div_quo, load && flags[DATA_WIDTH].zero_div,
                    rsp_quotient == '0, "nonzero quotient for zero divisor")

endmodule

/* tb/int64_divide_remainder_test.sv */
// Self-checking testbench for the pipelined 64-bit divider with quotient and remainder.
module int64_divide_remainder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W            = idr_pkg::PORT_WIDTH;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 200000;

   localparam logic [W-1:0] ALL_ONES = '1;
   localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

   typedef struct packed {
      logic [W-1:0] quotient;
      logic [W-1:0] remainder;
   } quot_rem_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   logic         req_signed_mode;
   logic [W-1:0] req_dividend;
   logic [W-1:0] req_divisor;
   logic         rsp_valid;
   logic         rsp_ready;
   logic [W-1:0] rsp_quotient;
   logic [W-1:0] rsp_remainder;

   quot_rem_type pending_results[$];
   int        error_count   = 0;
   int        cycle_count   = 0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        hold_cycles   = 0;

   int64_divide_remainder u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_signed_mode (req_signed_mode),
      .req_dividend    (req_dividend),
      .req_divisor     (req_divisor),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_quotient    (rsp_quotient),
      .rsp_remainder   (rsp_remainder)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Truncating division (magnitudes, then signs); zero divisor: quotient 0, rem = num.
   function automatic quot_rem_type predict_division(logic signed_mode, logic [W-1:0] num,
                                                     logic [W-1:0] den);
      quot_rem_type res;
      logic         num_neg;
      logic         den_neg;
      logic [W-1:0] num_mag;
      logic [W-1:0] den_mag;
      num_neg = signed_mode & num[W-1];
      den_neg = signed_mode & den[W-1];
      if (den == '0) begin
         res.quotient  = '0;
         res.remainder = num;
         return res;
      end
      num_mag = num_neg ? -num : num;
      den_mag = den_neg ? -den : den;
      res.quotient  = num_mag / den_mag;
      res.remainder = num_mag % den_mag;
      if (num_neg != den_neg) res.quotient = -res.quotient;
      if (num_neg) res.remainder = -res.remainder;
      return res;
   endfunction

   function automatic logic [W-1:0] random_operand();
      logic [W-1:0] full;
      full = {$urandom, $urandom};
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(5))
               0: return '0;
               1: return 1;
               2: return ALL_ONES;
               3: return MOST_NEG;
               4: return MOST_POS;
               default: return 2;
            endcase
         end
         1: return W'($urandom_range(15));
         2: return -W'($urandom_range(15, 1));
         3: return W'($urandom);
         4: return full >> $urandom_range(W - 1);
         default: return full;
      endcase
   endfunction

   // Drive one transaction; valid is dropped only when an idle gap is taken.
   task automatic send_division(logic signed_mode, logic [W-1:0] num, logic [W-1:0] den);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_signed_mode <= signed_mode;
      req_dividend    <= num;
      req_divisor     <= den;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(predict_division(signed_mode, num, den));
   endtask

   task automatic send_random(int count);
      repeat (count) send_division(1'($urandom_range(1)), random_operand(), random_operand());
   endtask

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      quot_rem_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: quotient %h remainder %h",
                   rsp_quotient, rsp_remainder);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_quotient !== want.quotient) begin
               $error("quotient mismatch: expected %h, actual %h", want.quotient, rsp_quotient);
               error_count++;
            end
            if (rsp_remainder !== want.remainder) begin
               $error("remainder mismatch: expected %h, actual %h",
                      want.remainder, rsp_remainder);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic test_corner_cases();
      send_division(1'b0, 64'd12345, '0);            // zero divisor, unsigned
      send_division(1'b1, -64'sd77, '0);             // zero divisor, signed
      send_division(1'b1, MOST_NEG, ALL_ONES);       // wraps to itself
      send_division(1'b1, MOST_NEG, 64'd1);
      send_division(1'b1, MOST_NEG, MOST_NEG);
      send_division(1'b1, MOST_NEG, 64'd3);
      send_division(1'b1, MOST_POS, MOST_NEG);
      send_division(1'b0, MOST_NEG, ALL_ONES);
      send_division(1'b0, ALL_ONES, 64'd1);
      send_division(1'b0, ALL_ONES, ALL_ONES);
      send_division(1'b0, ALL_ONES, 64'h8000_0000_0000_0001);  // divisor above half range
      send_division(1'b0, 64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF);
      send_division(1'b0, '0, 64'd5);
      send_division(1'b1, -64'sd7, 64'd2);
      send_division(1'b1, 64'd7, -64'sd2);
      send_division(1'b1, -64'sd7, -64'sd2);
      send_division(1'b1, '0, ALL_ONES);
      send_division(1'b1, 64'd5, 64'd9);
      send_division(1'b0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA);
      send_division(1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555);
   endtask

   task automatic test_sender_gaps();
      send_idle_pct = 28;
      recv_idle_pct = 88;
      send_random(130);
   endtask

   task automatic test_receiver_stalls();
      send_idle_pct = 88;
      recv_idle_pct = 28;
      send_random(130);
   endtask

   task automatic test_full_rate();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(100);
   endtask

   // Long receiver hold-off so the pipeline fills and stalls its input.
   task automatic test_output_hold();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles   = 400;
      send_random(80);
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_signed_mode <= 1'b0;
      req_dividend    <= '0;
      req_divisor     <= '0;
      rsp_ready       <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_cases();
      test_sender_gaps();
      test_receiver_stalls();
      test_full_rate();
      test_output_hold();
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) error_count++;

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/idr_pkg.sv
rtl/idr_prep.sv
rtl/idr_cell.sv
rtl/idr_fix.sv
rtl/int64_divide_remainder.sv
tb/int64_divide_remainder_test.sv
